@@ rtl/lsfe_pkg.sv @@
// Package for the LED strip frame encoder: mode and register codes, queue entry type,
// byte sequence steps and the divide-by-255 helper. No dependencies.
`default_nettype none
package lsfe_pkg;

	typedef enum logic {
		MODE_APA102 = 1'b0,
		MODE_WS2812 = 1'b1
	} lsfe_mode_t;

	localparam logic [1:0] CFG_STRIP_MODE = 2'd0;
	localparam logic [1:0] CFG_LED_COUNT  = 2'd1;
	localparam logic [1:0] CFG_BRIGHTNESS = 2'd2;

	localparam logic [7:0] APA_HEAD_MARK = 8'hE0;
	localparam logic [7:0] APA_START     = 8'h00;
	localparam logic [7:0] APA_END       = 8'hFF;

	// byte position within the longest pixel sequence
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_START = 4'd0;
	localparam logic [STEP_W-1:0] STEP_HEAD  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_C0    = 4'd5;
	localparam logic [STEP_W-1:0] STEP_C1    = 4'd6;
	localparam logic [STEP_W-1:0] STEP_C2    = 4'd7;
	localparam logic [STEP_W-1:0] STEP_LAST  = 4'd11;

	typedef struct packed {
		lsfe_mode_t  mode;
		logic        first;
		logic        last;
		logic [7:0]  head;
		logic [15:0] c0;
		logic [15:0] c1;
		logic [15:0] c2;
	} lsfe_entry_t;

	// floor(x / 255) for x <= 255*255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		begin
			s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
			div255 = s[15:8];
		end
	endfunction

endpackage
`default_nettype wire

@@ rtl/led_strip_frame_encoder_top.sv @@
// LED strip frame encoder, top level: config registers, front end, queue, back end.
// Depends on lsfe_pkg, lsfe_front, lsfe_queue, lsfe_back.
//
// Usage: pixels (red, green, blue) enter on the in_valid/in_ready channel; bytes for
// the strip leave on out_valid/out_ready as wire_byte with run_last on the last byte
// of each pixel and strip_done on the final byte of a strip frame.
// Registers are written on cfg_valid/cfg_ready (always ready): index 0 strip_mode,
// 1 led_count, 2 brightness; other indexes are ignored. Write them only when idle.
// A pixel is written into the queue, then its first byte into the output register.
// Throughput: the back end emits one byte per cycle while out_ready is high, so an
// APA102 pixel is 4 bytes (8 on the first or last pixel of a frame, 12 on a one-LED
// frame) and a WS2812 pixel 3 bytes. The queue of QUEUE_DEPTH pixels lets the front
// accept while the back end is still emitting.
// Reset clears the pixel index, queue and output valid flag and loads the register
// defaults (APA102, one LED, full brightness). When out_ready is low the current
// byte holds and the queue fills; in_ready drops once it is full.
`default_nettype none
module led_strip_frame_encoder_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       wire_byte,
	output logic             run_last,
	output logic             strip_done,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import lsfe_pkg::*;

	lsfe_mode_t  strip_mode_q;
	logic [15:0] led_count_q;
	logic [7:0]  brightness_q;

	logic        q_full;
	logic        q_push;
	logic        q_pop;
	logic        q_valid;
	lsfe_entry_t q_wr;
	lsfe_entry_t q_rd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_mode_q <= MODE_APA102;
			led_count_q  <= 16'd1;
			brightness_q <= 8'd255;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STRIP_MODE: strip_mode_q <= lsfe_mode_t'(cfg_data[0]);
				CFG_LED_COUNT:  led_count_q  <= cfg_data;
				CFG_BRIGHTNESS: brightness_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	lsfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.strip_mode (strip_mode_q),
		.led_count  (led_count_q),
		.brightness (brightness_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wr)
	);

	lsfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_data  (q_wr),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_rd)
	);

	lsfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_data     (q_rd),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.wire_byte  (wire_byte),
		.run_last   (run_last),
		.strip_done (strip_done)
	);

endmodule
`default_nettype wire

@@ rtl/lsfe_front.sv @@
// Front end: accepts pixels, tracks the pixel index, classifies first/last and
// builds one queue entry per pixel (WS2812 products formed here). Uses lsfe_pkg.
`default_nettype none
module lsfe_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         red,
	input  wire logic [7:0]         green,
	input  wire logic [7:0]         blue,
	input  wire lsfe_pkg::lsfe_mode_t strip_mode,
	input  wire logic [15:0]        led_count,
	input  wire logic [7:0]         brightness,
	input  wire logic               q_full,
	output logic                    q_push,
	output lsfe_pkg::lsfe_entry_t   q_data
);
	import lsfe_pkg::*;

	logic [15:0] pixel_index_q;
	logic [15:0] last_idx;
	logic        is_first;
	logic        is_last;
	logic [15:0] prod_r;
	logic [15:0] prod_g;
	logic [15:0] prod_b;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	assign last_idx = led_count - 16'd1;
	assign is_first = (pixel_index_q == 16'd0);
	assign is_last  = (pixel_index_q >= last_idx);

	assign prod_r = red * brightness;
	assign prod_g = green * brightness;
	assign prod_b = blue * brightness;

	always_comb begin
		q_data.mode  = strip_mode;
		q_data.first = is_first;
		q_data.last  = is_last;
		q_data.head  = APA_HEAD_MARK | {3'd0, brightness[7:3]};
		if (strip_mode == MODE_WS2812) begin
			q_data.c0 = prod_g;
			q_data.c1 = prod_r;
			q_data.c2 = prod_b;
		end else begin
			q_data.c0 = {8'd0, blue};
			q_data.c1 = {8'd0, green};
			q_data.c2 = {8'd0, red};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_index_q <= 16'd0;
		end else if (q_push) begin
			pixel_index_q <= is_last ? 16'd0 : pixel_index_q + 16'd1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/lsfe_queue.sv @@
// Small show-ahead register queue between front and back end.
// Holds lsfe_entry_t beats; uses lsfe_pkg.
`default_nettype none
module lsfe_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire lsfe_pkg::lsfe_entry_t wr_data,
	output logic                       full,
	input  wire logic                  pop,
	output logic                       rd_valid,
	output lsfe_pkg::lsfe_entry_t      rd_data
);
	import lsfe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lsfe_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/lsfe_back.sv @@
// Back end: walks the byte sequence of the queue head entry, one byte per cycle
// unless out_ready stalls it, into the output register. Uses lsfe_pkg.
`default_nettype none
module lsfe_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire lsfe_pkg::lsfe_entry_t q_data,
	output logic                       q_pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 wire_byte,
	output logic                       run_last,
	output logic                       strip_done
);
	import lsfe_pkg::*;

	logic              started_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [7:0]        byte_q;
	logic              run_last_q;
	logic              done_q;

	logic [STEP_W-1:0] start_s;
	logic [STEP_W-1:0] end_s;
	logic [STEP_W-1:0] cur;
	logic [15:0]       chan;
	logic [7:0]        nxt_byte;
	logic              load;
	logic              emit;
	logic              at_end;

	always_comb begin
		if (q_data.mode == MODE_WS2812) begin
			start_s = STEP_C0;
			end_s   = STEP_C2;
		end else begin
			start_s = q_data.first ? STEP_START : STEP_HEAD;
			end_s   = q_data.last ? STEP_LAST : STEP_C2;
		end
		cur    = started_q ? step_q : start_s;
		at_end = (cur == end_s);

		case (cur)
			STEP_C0: chan = q_data.c0;
			STEP_C1: chan = q_data.c1;
			default: chan = q_data.c2;
		endcase

		if (cur inside {[STEP_START:STEP_HEAD - 4'd1]}) begin
			nxt_byte = APA_START;
		end else if (cur == STEP_HEAD) begin
			nxt_byte = q_data.head;
		end else if (cur inside {[STEP_C0:STEP_C2]}) begin
			nxt_byte = (q_data.mode == MODE_WS2812) ? div255(chan) : chan[7:0];
		end else begin
			nxt_byte = APA_END;
		end
	end

	assign load  = !out_valid_q || out_ready;
	assign emit  = load && q_valid;
	assign q_pop = emit && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			step_q      <= STEP_START;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= q_valid;
			end
			if (emit) begin
				started_q <= !at_end;
				step_q    <= cur + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q     <= nxt_byte;
			run_last_q <= at_end;
			done_q     <= at_end && q_data.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign wire_byte  = byte_q;
	assign run_last   = run_last_q;
	assign strip_done = done_q;

endmodule
`default_nettype wire

@@ rtl/lsfe_checker.sv @@
// Port-level checks for led_strip_frame_encoder_top, attached by bind.
// No package dependencies.
`default_nettype none
module lsfe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] wire_byte,
	input wire logic       run_last,
	input wire logic       strip_done,
	input wire logic       cfg_valid,
	input wire logic       cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(wire_byte)
			&& $stable(run_last) && $stable(strip_done))
		else $error("output beat changed while stalled");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && strip_done |-> run_last)
		else $error("frame end not on a pixel's last byte");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

	a_out_follows_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 !out_valid |=> out_valid)
		else $error("no output beat after accepted pixel");

endmodule

bind led_strip_frame_encoder_top lsfe_checker u_lsfe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.wire_byte  (wire_byte),
	.run_last   (run_last),
	.strip_done (strip_done),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready)
);
`default_nettype wire
